// File: rtl/spiee_pkg.sv
// shared types, opcodes and defaults for the spi eeprom write-behind sequencer
package spiee_pkg;

   localparam int DEF_QUEUE_DEPTH = 64;
   localparam int DEF_CACHE_BYTES = 256;

   // front-to-back transaction queue (power of two)
   localparam int FIFO_DEPTH = 2;
   localparam int FPTR_W     = $clog2(FIFO_DEPTH);
   localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_STEP  = 2'd2;

   localparam logic [7:0] OP_WREN  = 8'h06;
   localparam logic [7:0] OP_WRITE = 8'h02;
   localparam logic [7:0] OP_RDSR  = 8'h05;
   localparam logic [7:0] OP_WRDI  = 8'h04;
   localparam logic [7:0] OP_DUMMY = 8'h00;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] address;
      logic [7:0] write_data;
      logic       rx_valid;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       chip_select_n;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic [7:0] read_data;
      logic       seq_busy;
      logic       queue_dropped;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_STEP  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] address;
      logic [7:0] write_data;
      logic       rx_valid;
      logic       rx_wip;
   } item_type;

   typedef enum logic [12:0] {
      S_IDLE        = 13'b0000000000001,
      S_RXWAIT      = 13'b0000000000010,
      S_ENABLE      = 13'b0000000000100,
      S_CMD         = 13'b0000000001000,
      S_ADDR        = 13'b0000000010000,
      S_DATA        = 13'b0000000100000,
      S_DATA_END    = 13'b0000001000000,
      S_STAT_CMD    = 13'b0000010000000,
      S_STAT_DUMMY  = 13'b0000100000000,
      S_STAT_CHECK  = 13'b0001000000000,
      S_DISABLE     = 13'b0010000000000,
      S_DISABLE_END = 13'b0100000000000,
      S_DONE        = 13'b1000000000000
   } seq_state_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'b01,
      PH_EXEC = 2'b10
   } phase_type;

endpackage

// File: rtl/spi_eeprom_write_behind_sequencer.sv
// top level of the spi eeprom write-behind sequencer
//
//   channel   direction  handshake            payload
//   req_*     in         req_valid/req_stall  req_type (command, address, data, rx)
//   rsp_*     out        rsp_valid/rsp_stall  rsp_type (chip select, tx, read data, flags)
//
// each transaction passes through the front queue, the registered cache and ring ram
// reads and the sequencer update into the output register; the back end takes a new
// transaction only once the last one has committed, which rsp_stall can hold off.
// reset is synchronous; the cache reads as zero through per-byte valid flags, no clear pass.
// rsp_stall holds the output register and the back end; the two-entry front queue
// keeps accepting until full.
module spi_eeprom_write_behind_sequencer
   import spiee_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int CACHE_BYTES = DEF_CACHE_BYTES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic     item_valid;
   item_type item;
   logic     item_pop;

   spiee_front #(
      .CACHE_BYTES(CACHE_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .item_valid(item_valid),
      .item      (item),
      .item_pop  (item_pop)
   );

   spiee_back #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .CACHE_BYTES(CACHE_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .item_valid(item_valid),
      .item      (item),
      .item_pop  (item_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/spiee_ram.sv
// generic single-write, single-read ram with registered read data
module spiee_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/spiee_front.sv
// front end: accepts request transactions, classifies them, queues them for the back end
module spiee_front
   import spiee_pkg::*;
#(
   parameter int CACHE_BYTES = DEF_CACHE_BYTES
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   output logic     item_valid,
   output item_type item,
   input  logic     item_pop
);

   logic [FPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FCNT_W-1:0] count_ff, count_in;
   item_type          fifo_ff [FIFO_DEPTH];
   item_type          entry_in;
   logic              in_cache;
   logic              push;

   // out-of-range host accesses behave like the unused command
   always_comb begin
      in_cache            = ({1'b0, req_data.address} < 9'(CACHE_BYTES));
      entry_in.address    = req_data.address;
      entry_in.write_data = req_data.write_data;
      entry_in.rx_valid   = req_data.rx_valid;
      entry_in.rx_wip     = req_data.rx_byte[0];
      unique case (req_data.command)
         CMD_WRITE: entry_in.kind = in_cache ? KIND_WRITE : KIND_NONE;
         CMD_READ:  entry_in.kind = in_cache ? KIND_READ : KIND_NONE;
         CMD_STEP:  entry_in.kind = KIND_STEP;
         default:   entry_in.kind = KIND_NONE;
      endcase
   end

   assign req_stall  = (count_ff == FCNT_W'(FIFO_DEPTH));
   assign push       = req_valid && !req_stall;
   assign item_valid = (count_ff != '0);
   assign item       = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = item_pop ? rd_ptr_ff + FPTR_W'(1) : rd_ptr_ff;
      unique case ({push, item_pop})
         2'b10:   count_in = count_ff + FCNT_W'(1);
         2'b01:   count_in = count_ff - FCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

// File: rtl/spiee_back.sv
// back end: byte cache, pending address ring and the spi write sequencer
module spiee_back
   import spiee_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int CACHE_BYTES = DEF_CACHE_BYTES
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     item_valid,
   input  item_type item,
   output logic     item_pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
   localparam int CADDR_W = $clog2(CACHE_BYTES);

   function automatic logic [QPTR_W-1:0] qnext(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] r;
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + QPTR_W'(1);
      end
      return r;
   endfunction

   phase_type          phase_ff, phase_in;
   seq_state_type      seq_ff, seq_in;
   seq_state_type      resume_ff, resume_in;
   logic [7:0]         target_ff, target_in;
   logic               wip_ff, wip_in;
   logic               busy_ff, busy_in;
   logic               cs_ff, cs_in;
   logic [QPTR_W-1:0]  head_ff, head_in;
   logic [QPTR_W-1:0]  tail_ff, tail_in;
   logic [CACHE_BYTES-1:0] cache_vld_ff, cache_vld_in;
   item_type           cur_ff;
   logic               hit_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               commit;
   logic [CADDR_W-1:0] cache_rd_addr;
   logic [7:0]         cache_rd;
   logic               cache_we;
   logic [7:0]         q_rd;
   logic               q_we;
   logic [QPTR_W-1:0]  q_next_head;
   logic [QPTR_W-1:0]  q_next_tail;
   logic               tx_v;
   logic [7:0]         tx_b;
   logic [7:0]         rdata;
   logic               dropped;

   assign item_pop      = (phase_ff == PH_IDLE) && item_valid;
   assign commit        = (phase_ff == PH_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign q_next_head   = qnext(head_ff);
   assign q_next_tail   = qnext(tail_ff);
   assign cache_rd_addr = (item.kind == KIND_READ) ? item.address[CADDR_W-1:0]
                                                  : target_ff[CADDR_W-1:0];

   spiee_ram #(
      .WIDTH(8),
      .DEPTH(CACHE_BYTES)
   ) u_cache (
      .clock  (clock),
      .wr_en  (cache_we),
      .wr_addr(cur_ff.address[CADDR_W-1:0]),
      .wr_data(cur_ff.write_data),
      .rd_en  (item_pop),
      .rd_addr(cache_rd_addr),
      .rd_data(cache_rd)
   );

   spiee_ram #(
      .WIDTH(8),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .wr_en  (q_we),
      .wr_addr(q_next_head),
      .wr_data(cur_ff.address),
      .rd_en  (item_pop),
      .rd_addr(q_next_tail),
      .rd_data(q_rd)
   );

   always_comb begin
      seq_in       = seq_ff;
      resume_in    = resume_ff;
      target_in    = target_ff;
      wip_in       = wip_ff;
      busy_in      = busy_ff;
      cs_in        = cs_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cache_vld_in = cache_vld_ff;
      cache_we     = 1'b0;
      q_we         = 1'b0;
      tx_v         = 1'b0;
      tx_b         = '0;
      rdata        = '0;
      dropped      = 1'b0;
      if (commit) begin
         unique case (cur_ff.kind)
            KIND_WRITE: begin
               cache_we = 1'b1;
               cache_vld_in[cur_ff.address[CADDR_W-1:0]] = 1'b1;
               if (seq_ff == S_IDLE) begin
                  target_in = cur_ff.address;
                  cs_in     = 1'b0;
                  resume_in = S_ENABLE;
                  seq_in    = S_RXWAIT;
                  tx_v      = 1'b1;
                  tx_b      = OP_WREN;
               end else if (q_next_head == tail_ff) begin
                  dropped = 1'b1;
               end else begin
                  q_we    = 1'b1;
                  head_in = q_next_head;
               end
            end
            KIND_READ: begin
               rdata = hit_ff ? cache_rd : '0;
            end
            KIND_STEP: begin
               unique case (seq_ff)
                  S_RXWAIT: begin
                     if (cur_ff.rx_valid) begin
                        wip_in = cur_ff.rx_wip;
                        seq_in = resume_ff;
                     end
                  end
                  S_ENABLE: begin
                     busy_in = 1'b1;
                     cs_in   = 1'b1;
                     seq_in  = S_CMD;
                  end
                  S_CMD: begin
                     cs_in     = 1'b0;
                     resume_in = S_ADDR;
                     seq_in    = S_RXWAIT;
                     tx_v      = 1'b1;
                     tx_b      = OP_WRITE;
                  end
                  S_ADDR: begin
                     resume_in = S_DATA;
                     seq_in    = S_RXWAIT;
                     tx_v      = 1'b1;
                     tx_b      = target_ff;
                  end
                  S_DATA: begin
                     resume_in = S_DATA_END;
                     seq_in    = S_RXWAIT;
                     tx_v      = 1'b1;
                     tx_b      = hit_ff ? cache_rd : '0;
                  end
                  S_DATA_END: begin
                     cs_in  = 1'b1;
                     seq_in = S_STAT_CMD;
                  end
                  S_STAT_CMD: begin
                     cs_in     = 1'b0;
                     resume_in = S_STAT_DUMMY;
                     seq_in    = S_RXWAIT;
                     tx_v      = 1'b1;
                     tx_b      = OP_RDSR;
                  end
                  S_STAT_DUMMY: begin
                     resume_in = S_STAT_CHECK;
                     seq_in    = S_RXWAIT;
                     tx_v      = 1'b1;
                     tx_b      = OP_DUMMY;
                  end
                  S_STAT_CHECK: begin
                     cs_in  = 1'b1;
                     seq_in = wip_ff ? S_STAT_CMD : S_DISABLE;
                  end
                  S_DISABLE: begin
                     cs_in     = 1'b0;
                     resume_in = S_DISABLE_END;
                     seq_in    = S_RXWAIT;
                     tx_v      = 1'b1;
                     tx_b      = OP_WRDI;
                  end
                  S_DISABLE_END: begin
                     cs_in = 1'b1;
                     if (head_ff == tail_ff) begin
                        seq_in = S_DONE;
                     end else begin
                        // drain the next pending address
                        tail_in   = q_next_tail;
                        target_in = q_rd;
                        cs_in     = 1'b0;
                        resume_in = S_ENABLE;
                        seq_in    = S_RXWAIT;
                        tx_v      = 1'b1;
                        tx_b      = OP_WREN;
                     end
                  end
                  S_DONE: begin
                     busy_in = 1'b0;
                     seq_in  = S_IDLE;
                  end
                  S_IDLE: begin
                  end
                  default: begin
                  end
               endcase
            end
            KIND_NONE: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (phase_ff)
         PH_IDLE: phase_in = item_pop ? PH_EXEC : PH_IDLE;
         PH_EXEC: phase_in = commit ? PH_IDLE : PH_EXEC;
         default: phase_in = PH_IDLE;
      endcase
      rsp_valid_in         = commit || (rsp_valid_ff && rsp_stall);
      rsp_in.chip_select_n = cs_in;
      rsp_in.tx_valid      = tx_v;
      rsp_in.tx_byte       = tx_b;
      rsp_in.read_data     = rdata;
      rsp_in.seq_busy      = busy_in;
      rsp_in.queue_dropped = dropped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         seq_ff       <= S_IDLE;
         resume_ff    <= S_IDLE;
         target_ff    <= '0;
         wip_ff       <= 1'b0;
         busy_ff      <= 1'b0;
         cs_ff        <= 1'b1;
         head_ff      <= '0;
         tail_ff      <= '0;
         cache_vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         seq_ff       <= seq_in;
         resume_ff    <= resume_in;
         target_ff    <= target_in;
         wip_ff       <= wip_in;
         busy_ff      <= busy_in;
         cs_ff        <= cs_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cache_vld_ff <= cache_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         cur_ff <= item;
         hit_ff <= cache_vld_ff[cache_rd_addr];
      end
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/spiee_checker.sv
// port-level assertions for the spi eeprom write-behind sequencer, bound to the top level
module spiee_checker
   import spiee_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled request transaction holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("request changed while stalled");

   // a stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // bytes are only shifted out with the device selected
   a_tx_selected: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.tx_valid |-> !rsp_data.chip_select_n)
      else $error("tx byte with chip select inactive");

   // a dropped write neither transmits nor returns read data
   a_drop_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.queue_dropped |->
         !rsp_data.tx_valid && (rsp_data.read_data == 8'h00))
      else $error("dropped write with side effects");

   // no response right after reset, and the front accepts again
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("channels not cleared by reset");

endmodule

bind spi_eeprom_write_behind_sequencer spiee_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

// File: verif/tb_spi_eeprom_write_behind_sequencer.sv
// self-checking testbench for the spi eeprom write-behind sequencer
module tb_spi_eeprom_write_behind_sequencer;
   import spiee_pkg::*;

   localparam logic [1:0] CMD_NONE = 2'd3;
   localparam int NUM_ITEMS  = 2000;
   localparam int IDLE_LIMIT = 2000;
   localparam int QPTR_W     = $clog2(DEF_QUEUE_DEPTH);

   typedef struct {
      req_type req;
      bit      hold;
   } pending_txn_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   pending_txn_type pending_txns[$];
   rsp_type         due_rsps[$];
   int              fail_count = 0;

   // shadow of the sequencer
   logic [7:0]        cache_img [DEF_CACHE_BYTES];
   logic [7:0]        ring_img [DEF_QUEUE_DEPTH];
   logic [QPTR_W-1:0] ring_head = '0;
   logic [QPTR_W-1:0] ring_tail = '0;
   seq_state_type     seq_now = S_IDLE;
   seq_state_type     seq_resume = S_IDLE;
   logic [7:0]        target_addr = '0;
   logic [7:0]        status_byte = '0;
   logic              busy_now = 1'b0;
   logic              csn_now = 1'b1;
   logic              tx_on;
   logic [7:0]        tx_val;

   spi_eeprom_write_behind_sequencer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic shift_out(input logic [7:0] value, input seq_state_type nxt);
      seq_resume = nxt;
      seq_now = S_RXWAIT;
      tx_on = 1'b1;
      tx_val = value;
   endtask

   task automatic launch_write(input logic [7:0] addr);
      target_addr = addr;
      csn_now = 1'b0;
      shift_out(OP_WREN, S_ENABLE);
   endtask

   task automatic predict_eeprom_response(input req_type r);
      rsp_type o;
      o = '0;
      tx_on = 1'b0;
      tx_val = '0;
      case (r.command)
         CMD_WRITE: begin
            cache_img[r.address] = r.write_data;
            if (seq_now == S_IDLE) begin
               launch_write(r.address);
            end else if (QPTR_W'(ring_head + 1'b1) == ring_tail) begin
               o.queue_dropped = 1'b1;
            end else begin
               ring_head = ring_head + 1'b1;
               ring_img[ring_head] = r.address;
            end
         end
         CMD_READ: o.read_data = cache_img[r.address];
         CMD_STEP: begin
            case (seq_now)
               S_RXWAIT: if (r.rx_valid) begin
                  status_byte = r.rx_byte;
                  seq_now = seq_resume;
               end
               S_ENABLE: begin
                  busy_now = 1'b1;
                  csn_now = 1'b1;
                  seq_now = S_CMD;
               end
               S_CMD: begin
                  csn_now = 1'b0;
                  shift_out(OP_WRITE, S_ADDR);
               end
               S_ADDR: shift_out(target_addr, S_DATA);
               S_DATA: shift_out(cache_img[target_addr], S_DATA_END);
               S_DATA_END: begin
                  csn_now = 1'b1;
                  seq_now = S_STAT_CMD;
               end
               S_STAT_CMD: begin
                  csn_now = 1'b0;
                  shift_out(OP_RDSR, S_STAT_DUMMY);
               end
               S_STAT_DUMMY: shift_out(OP_DUMMY, S_STAT_CHECK);
               S_STAT_CHECK: begin
                  csn_now = 1'b1;
                  seq_now = status_byte[0] ? S_STAT_CMD : S_DISABLE;
               end
               S_DISABLE: begin
                  csn_now = 1'b0;
                  shift_out(OP_WRDI, S_DISABLE_END);
               end
               S_DISABLE_END: begin
                  csn_now = 1'b1;
                  if (ring_head == ring_tail) begin
                     seq_now = S_DONE;
                  end else begin
                     ring_tail = ring_tail + 1'b1;
                     launch_write(ring_img[ring_tail]);
                  end
               end
               S_DONE: begin
                  busy_now = 1'b0;
                  seq_now = S_IDLE;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      o.tx_valid = tx_on;
      o.tx_byte = tx_val;
      o.chip_select_n = csn_now;
      o.seq_busy = busy_now;
      due_rsps.push_back(o);
   endtask

   task automatic check_field(input string tag, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, tag, want, got);
         fail_count++;
      end
   endtask

   function automatic req_type make_req(input logic [1:0] cmd);
      req_type r;
      r.command = cmd;
      r.address = 8'($urandom_range(0, 255));
      r.write_data = 8'($urandom_range(0, 255));
      r.rx_valid = ($urandom_range(0, 3) != 0);
      r.rx_byte = 8'($urandom_range(0, 255));
      return r;
   endfunction

   task automatic add_txn(input req_type r, input bit hold);
      pending_txn_type p;
      p.req = r;
      p.hold = hold;
      pending_txns.push_back(p);
   endtask

   // driver: bursts with random gaps, optional hold until all responses are back
   int gap_left = 0;
   int burst_left = 0;
   int req_count = 0;

   always @(posedge clock) begin
      logic    fire;
      logic    nxt_valid;
      req_type nxt_data;
      fire = req_valid && !req_stall;
      nxt_valid = req_valid && !fire;
      nxt_data = req_data;
      if (reset) begin
         nxt_valid = 1'b0;
      end else begin
         if (fire) begin
            predict_eeprom_response(req_data);
            req_count++;
         end
         if (!nxt_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_txns.size() != 0 &&
                         !(pending_txns[0].hold && due_rsps.size() != 0)) begin
               nxt_data = pending_txns[0].req;
               nxt_valid = 1'b1;
               void'(pending_txns.pop_front());
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
               end
            end
         end
      end
      req_valid <= nxt_valid;
      req_data <= nxt_data;
   end

   // monitor: compare responses, stall in modes of its own
   int stall_mode = 0;
   int stall_run = 0;
   int mode_cycles = 0;
   int rsp_count = 0;

   always @(posedge clock) begin
      rsp_type want;
      logic    nxt_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (due_rsps.size() == 0) begin
            $display("%0t: unexpected response, expected none actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            want = due_rsps.pop_front();
            check_field("chip_select_n", 32'(want.chip_select_n),
                        32'(rsp_data.chip_select_n));
            check_field("tx_valid", 32'(want.tx_valid), 32'(rsp_data.tx_valid));
            check_field("tx_byte", 32'(want.tx_byte), 32'(rsp_data.tx_byte));
            check_field("read_data", 32'(want.read_data), 32'(rsp_data.read_data));
            check_field("seq_busy", 32'(want.seq_busy), 32'(rsp_data.seq_busy));
            check_field("queue_dropped", 32'(want.queue_dropped),
                        32'(rsp_data.queue_dropped));
         end
      end
      if (mode_cycles == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_cycles = $urandom_range(20, 120);
      end else begin
         mode_cycles--;
      end
      nxt_stall = 1'b0;
      if (stall_run > 0) begin
         stall_run--;
         nxt_stall = 1'b1;
      end else if (stall_mode == 1) begin
         nxt_stall = 1'($urandom_range(0, 1));
      end else if (stall_mode == 2 && $urandom_range(0, 9) == 0) begin
         stall_run = $urandom_range(2, 8);
         nxt_stall = 1'b1;
      end
      rsp_stall <= nxt_stall;
   end

   // watchdog on cycles without any transaction
   int idle_cycles = 0;
   int last_total = 0;

   always @(posedge clock) begin
      if (reset || req_count + rsp_count != last_total) begin
         idle_cycles = 0;
         last_total = req_count + rsp_count;
      end else if (++idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      req_type r;
      int      seg;
      int      n;
      int      pick;
      int      total;

      foreach (cache_img[i]) cache_img[i] = '0;

      // directed: empty cache reads, unused command, idle step, start and queue
      r = make_req(CMD_READ);  r.address = 8'h00; add_txn(r, 0);
      r = make_req(CMD_READ);  r.address = 8'hFF; add_txn(r, 0);
      r = make_req(CMD_NONE);  add_txn(r, 0);
      r = make_req(CMD_STEP);  add_txn(r, 0);
      r = make_req(CMD_WRITE); r.address = 8'hFF; r.write_data = 8'hFF; add_txn(r, 0);
      r = make_req(CMD_WRITE); r.address = 8'h00; r.write_data = 8'h00; add_txn(r, 0);
      r = make_req(CMD_READ);  r.address = 8'hFF; add_txn(r, 0);
      r = make_req(CMD_STEP);  r.rx_valid = 1'b0; add_txn(r, 0);
      r = make_req(CMD_STEP);  r.rx_valid = 1'b1; r.rx_byte = 8'hFF; add_txn(r, 0);
      // status polling with wip set
      for (int i = 0; i < 14; i++) begin
         r = make_req(CMD_STEP);
         r.rx_valid = 1'b1;
         r.rx_byte = 8'h01;
         add_txn(r, 0);
      end

      total = pending_txns.size();
      seg = 0;
      while (total < NUM_ITEMS) begin
         if (seg == 1 || $urandom_range(0, 39) == 0) begin
            // write flood past the ring capacity
            n = $urandom_range(64, 72);
            for (int i = 0; i < n; i++)
               add_txn(make_req(CMD_WRITE), i == 0 && $urandom_range(0, 1) == 0);
         end else if ($urandom_range(0, 9) < 4) begin
            n = $urandom_range(40, 300);
            for (int i = 0; i < n; i++)
               add_txn(make_req(CMD_STEP), i == 0 && (seg == 0 || $urandom_range(0, 7) == 0));
         end else begin
            n = $urandom_range(10, 60);
            for (int i = 0; i < n; i++) begin
               pick = $urandom_range(0, 99);
               if (pick < 25)      r = make_req(CMD_WRITE);
               else if (pick < 40) r = make_req(CMD_READ);
               else if (pick < 95) r = make_req(CMD_STEP);
               else                r = make_req(CMD_NONE);
               add_txn(r, i == 0 && (seg == 0 || $urandom_range(0, 7) == 0));
            end
         end
         total += n;
         seg++;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_txns.size() != 0 || req_valid) @(posedge clock);
      while (due_rsps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (fail_count == 0 && due_rsps.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: spi_eeprom_write_behind_sequencer.f
rtl/spiee_pkg.sv
rtl/spiee_ram.sv
rtl/spiee_front.sv
rtl/spiee_back.sv
rtl/spi_eeprom_write_behind_sequencer.sv
rtl/spiee_checker.sv
verif/tb_spi_eeprom_write_behind_sequencer.sv
